>>> src/two_link_arm_inverse_kinematics_assert.svh
// Assertion macros for the arm kinematics block.
`ifndef TWO_LINK_ARM_INVERSE_KINEMATICS_ASSERT_SVH
`define TWO_LINK_ARM_INVERSE_KINEMATICS_ASSERT_SVH

// same-cycle implication
`define TLIK_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TLIK_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/tlik_pkg.sv
// ----------------------------------------------------------------------------
// tlik_pkg
// Types, constants and helper functions of the two-link arm kinematics block.
// ----------------------------------------------------------------------------
package tlik_pkg;

  localparam int ATAN_LEN    = 24;
  localparam int PI_Q24      = 52707179;
  localparam int HALF_PI_Q24 = 26353589;
  localparam int ONE_Q14     = 16384;

  localparam logic signed [15:0] LEVEL_TRIM_Q12 = -16'sd410;
  localparam logic signed [15:0] DOWN_TRIM_Q12  = 16'sd6390;

  typedef enum logic [2:0] {
    CFG_UPPER = 3'd0,
    CFG_LOWER = 3'd1,
    CFG_ELBOW = 3'd2,
    CFG_MAX   = 3'd3,
    CFG_MIN   = 3'd4,
    CFG_CLAW  = 3'd5
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_YY,
    ST_ZZ,
    ST_MX,
    ST_MN,
    ST_AA,
    ST_BB,
    ST_AB,
    ST_CHK,
    ST_BRG,
    ST_SQC_GO,
    ST_SQC,
    ST_DEN,
    ST_DIV_GO,
    ST_DIV,
    ST_RSQ,
    ST_SQR_GO,
    ST_SQR,
    ST_ACS,
    ST_FIN
  } state_t;

  // atan(2^-i) at 2^-24 rad
  function automatic logic signed [27:0] atan_q24(input logic [4:0] i);
    logic signed [27:0] v;
    case (i)
      5'd0:  v = 28'sd13176795;
      5'd1:  v = 28'sd7778716;
      5'd2:  v = 28'sd4110060;
      5'd3:  v = 28'sd2086331;
      5'd4:  v = 28'sd1047214;
      5'd5:  v = 28'sd524117;
      5'd6:  v = 28'sd262123;
      5'd7:  v = 28'sd131069;
      5'd8:  v = 28'sd65536;
      5'd9:  v = 28'sd32768;
      5'd10: v = 28'sd16384;
      5'd11: v = 28'sd8192;
      5'd12: v = 28'sd4096;
      5'd13: v = 28'sd2048;
      5'd14: v = 28'sd1024;
      5'd15: v = 28'sd512;
      5'd16: v = 28'sd256;
      5'd17: v = 28'sd128;
      5'd18: v = 28'sd64;
      5'd19: v = 28'sd32;
      5'd20: v = 28'sd16;
      5'd21: v = 28'sd8;
      5'd22: v = 28'sd4;
      5'd23: v = 28'sd2;
      default: v = 28'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [29:0] v);
    logic signed [15:0] r;
    if (v > 30'sd32767) r = 16'sh7fff;
    else if (v < -30'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [15:0] q24_to_q12(input logic signed [29:0] v);
    logic signed [29:0] t;
    t = (v + 30'sd2048) >>> 12;
    return sat16(t);
  endfunction

endpackage

>>> src/tlik_in_if.sv
// ----------------------------------------------------------------------------
// tlik_in_if
// Target point channel.
// ----------------------------------------------------------------------------
interface tlik_in_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] pos_y;
  logic signed [14:0] pos_z;
  modport source (output valid, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_y, pos_z, output ready);
endinterface

>>> src/tlik_out_if.sv
// ----------------------------------------------------------------------------
// tlik_out_if
// Joint angle result channel.
// ----------------------------------------------------------------------------
interface tlik_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] shoulder_angle;
  logic signed [15:0] elbow_angle;
  logic signed [15:0] wrist_angle;
  logic               reachable;
  modport source (output valid, shoulder_angle, elbow_angle, wrist_angle, reachable,
                  input ready);
  modport sink   (input valid, shoulder_angle, elbow_angle, wrist_angle, reachable,
                  output ready);
endinterface

>>> src/tlik_cfg_if.sv
// ----------------------------------------------------------------------------
// tlik_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface tlik_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/tlik_isqrt.sv
// ----------------------------------------------------------------------------
// tlik_isqrt
// Floor integer square root of a 48-bit value, two radicand bits a cycle.
// ----------------------------------------------------------------------------
module tlik_isqrt import tlik_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] val,
  output logic        done,
  output logic [23:0] root
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [47:0] v_r;
  logic [47:0] q_r;
  logic [47:0] bitv;
  logic [47:0] trial;

  assign bitv  = 48'd1 << {cnt_r, 1'b0};
  assign trial = q_r + bitv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd23;
      end else if (busy_r) begin
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r <= val;
      q_r <= '0;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r <= v_r - trial;
        q_r <= (q_r >> 1) + bitv;
      end else begin
        q_r <= q_r >> 1;
      end
    end
  end

  assign done = done_r;
  assign root = q_r[23:0];

endmodule

>>> src/tlik_div.sv
// ----------------------------------------------------------------------------
// tlik_div
// Rounded cosine ratio num/den in Q2.14, clamped to [-1, 1]; restoring
// division, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tlik_div import tlik_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic [37:0]        den,
  input  logic               shift_hi,   // 1: shift 22, 0: shift 14
  output logic               done,
  output logic signed [15:0] quot
);

  logic        busy_r;
  logic        first_r;
  logic        done_r;
  logic [3:0]  cnt_r;
  logic [53:0] rem_r;
  logic [37:0] den_r;
  logic [15:0] q_r;
  logic        ovf_r;
  logic        neg_r;
  logic        zero_r;
  logic [31:0] mag;
  logic [53:0] mag_sh;
  logic [53:0] trial;
  logic [15:0] qm;

  assign mag    = num[31] ? 32'(-num) : 32'(num);
  assign mag_sh = shift_hi ? {mag, 22'b0} : {8'b0, mag, 14'b0};
  assign trial  = {16'b0, den_r} << cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      first_r <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        first_r <= 1'b1;
      end else if (busy_r) begin
        if (first_r) begin
          first_r <= 1'b0;
          cnt_r   <= 4'd15;
        end else if (cnt_r == 4'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= mag_sh + {17'b0, den[37:1]};
      den_r  <= den;
      neg_r  <= num[31];
      zero_r <= (num == 32'sd0);
      q_r    <= '0;
    end else if (busy_r) begin
      if (first_r) begin
        // quotient of 2^16 or more, or a zero divisor: clamp
        ovf_r <= (rem_r >= {den_r, 16'b0});
      end else if (rem_r >= trial) begin
        rem_r        <= rem_r - trial;
        q_r[cnt_r]   <= 1'b1;
      end
    end
  end

  always_comb begin
    if (zero_r) qm = '0;
    else if (ovf_r || (q_r > 16'(ONE_Q14))) qm = 16'(ONE_Q14);
    else qm = q_r;
    quot = neg_r ? -$signed(qm) : $signed(qm);
  end

  assign done = done_r;

endmodule

>>> src/tlik_cordic.sv
// ----------------------------------------------------------------------------
// tlik_cordic
// Vectoring CORDIC: atan2(yy, xx) for yy >= 0, result in [0, pi] at 2^-24 rad.
// One micro-rotation a cycle.
// ----------------------------------------------------------------------------
module tlik_cordic import tlik_pkg::*; #(
  parameter int ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] yy,
  input  logic signed [15:0] xx,
  output logic               done,
  output logic signed [27:0] ang
);

  localparam int STEPS = (ITERATIONS > ATAN_LEN) ? ATAN_LEN : ITERATIONS;

  logic               busy_r;
  logic               done_r;
  logic [4:0]         cnt_r;
  logic signed [33:0] x_r;
  logic signed [33:0] y_r;
  logic signed [27:0] ang_r;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic               origin;

  assign origin = (xx == 16'sd0) && (yy == 16'sd0);
  assign xs     = x_r >>> cnt_r;
  assign ys     = y_r >>> cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= '0;
        if (origin) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (cnt_r == 5'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (origin) begin
        ang_r <= '0;
      end else if (xx < 16'sd0) begin
        // pre-rotate by -pi/2 into the right half plane
        x_r   <= 34'(yy) <<< 16;
        y_r   <= (-(34'(xx))) <<< 16;
        ang_r <= 28'(HALF_PI_Q24);
      end else begin
        x_r   <= 34'(xx) <<< 16;
        y_r   <= 34'(yy) <<< 16;
        ang_r <= '0;
      end
    end else if (busy_r) begin
      if (y_r >= 34'sd0) begin
        x_r   <= x_r + ys;
        y_r   <= y_r - xs;
        ang_r <= ang_r + atan_q24(cnt_r);
      end else begin
        x_r   <= x_r - ys;
        y_r   <= y_r + xs;
        ang_r <= ang_r - atan_q24(cnt_r);
      end
    end
  end

  assign done = done_r;
  assign ang  = ang_r;

endmodule

>>> src/two_link_arm_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// two_link_arm_inverse_kinematics
// Shoulder, elbow and wrist angles of a two-link arm with claw for a target
// point, by law of cosines with iterative sqrt, divide and CORDIC units.
//
//   channel  dir  word
//   in_ch    in   pos_y, pos_z (Q4 mm)
//   out_ch   out  shoulder/elbow/wrist angle (Q4.12 rad), reachable
//   cfg_ch   in   index, data (register write, always ready)
//
// An item in reach passes through three CORDIC runs of CORDIC_ITERATIONS
// micro-rotations (capped at 24), three square roots and two divisions, in
// turn, under one sequencer; a target outside the reach window goes from the
// reach check straight to the last step. The sequencer returns to idle
// before the next target is taken.
// in_ch is ready only in idle. A result waits in the output register and the
// next target is taken meanwhile; the sequencer stalls at its last step while
// an earlier result is not yet taken. Synchronous reset, no clearing pass.
// ----------------------------------------------------------------------------
module two_link_arm_inverse_kinematics import tlik_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  tlik_in_if.sink    in_ch,
  tlik_out_if.source out_ch,
  tlik_cfg_if.sink   cfg_ch
);

  state_t state_r, state_nxt;

  logic [12:0]        upper_r;
  logic [12:0]        lower_r;
  logic signed [15:0] elbow_off_r;
  logic [13:0]        max_r;
  logic [13:0]        min_r;
  logic               claw_r;

  logic signed [14:0] y_r;
  logic signed [14:0] z_r;
  logic [29:0]        c2_r;
  logic [27:0]        mx2_r;
  logic [27:0]        mn2_r;
  logic [25:0]        aa_r;
  logic [25:0]        bb_r;
  logic [25:0]        ab_r;
  logic [22:0]        cq_r;
  logic signed [15:0] r_r;
  logic signed [27:0] bearing_r;
  logic signed [27:0] ac1_r;
  logic signed [27:0] ac2_r;
  logic               pass_r;
  logic               reach_r;
  logic signed [49:0] prod_r;

  logic signed [15:0] sh_r;
  logic signed [15:0] el_r;
  logic signed [15:0] wr_r;
  logic               reach_out_r;
  logic               out_valid_r;

  logic signed [24:0] mul_a;
  logic signed [24:0] mul_b;
  logic               cor_start;
  logic signed [15:0] cor_yy;
  logic signed [15:0] cor_xx;
  logic               cor_done;
  logic signed [27:0] cor_ang;
  logic               sq_start;
  logic [47:0]        sq_val;
  logic               sq_done;
  logic [23:0]        sq_root;
  logic               dv_start;
  logic signed [31:0] dv_num;
  logic [37:0]        dv_den;
  logic               dv_hi;
  logic               dv_done;
  logic signed [15:0] dv_quot;

  logic               in_fire;
  logic               out_free;
  logic               in_reach;
  logic signed [31:0] num1;
  logic signed [31:0] num2;
  logic signed [29:0] sh_full;
  logic signed [29:0] el_full;
  logic signed [29:0] wr_full;
  logic signed [15:0] sh16;
  logic signed [15:0] el16;
  logic signed [15:0] wr16;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign in_reach = !((c2_r > {2'b0, mx2_r}) || (c2_r < {2'b0, mn2_r}));
  assign num1 = $signed({2'b0, c2_r}) + $signed({6'b0, bb_r}) - $signed({6'b0, aa_r});
  assign num2 = $signed({6'b0, aa_r}) + $signed({6'b0, bb_r}) - $signed({2'b0, c2_r});

  assign sh_full = 30'(PI_Q24) - (30'(ac1_r) + 30'(bearing_r));
  assign el_full = 30'(ac2_r) - 30'($signed({elbow_off_r, 12'b0}));
  assign sh16    = q24_to_q12(sh_full);
  assign el16    = q24_to_q12(el_full);
  assign wr_full = 30'(el16) - 30'(sh16) + 30'(claw_r ? DOWN_TRIM_Q12 : LEVEL_TRIM_Q12);
  assign wr16    = sat16(wr_full);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r     <= 13'd3021;
      lower_r     <= 13'd2880;
      elbow_off_r <= 16'sd1256;
      max_r       <= 14'd5760;
      min_r       <= 14'd141;
      claw_r      <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_UPPER: upper_r     <= cfg_ch.data[12:0];
        CFG_LOWER: lower_r     <= cfg_ch.data[12:0];
        CFG_ELBOW: elbow_off_r <= $signed(cfg_ch.data);
        CFG_MAX:   max_r       <= cfg_ch.data[13:0];
        CFG_MIN:   min_r       <= cfg_ch.data[13:0];
        CFG_CLAW:  claw_r      <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_YY;
      ST_YY:     state_nxt = ST_ZZ;
      ST_ZZ:     state_nxt = ST_MX;
      ST_MX:     state_nxt = ST_MN;
      ST_MN:     state_nxt = ST_AA;
      ST_AA:     state_nxt = ST_BB;
      ST_BB:     state_nxt = ST_AB;
      ST_AB:     state_nxt = ST_CHK;
      ST_CHK:    state_nxt = in_reach ? ST_BRG : ST_FIN;
      ST_BRG:    if (cor_done) state_nxt = ST_SQC_GO;
      ST_SQC_GO: state_nxt = ST_SQC;
      ST_SQC:    if (sq_done) state_nxt = ST_DEN;
      ST_DEN:    state_nxt = ST_DIV_GO;
      ST_DIV_GO: state_nxt = ST_DIV;
      ST_DIV:    if (dv_done) state_nxt = ST_RSQ;
      ST_RSQ:    state_nxt = ST_SQR_GO;
      ST_SQR_GO: state_nxt = ST_SQR;
      ST_SQR:    if (sq_done) state_nxt = ST_ACS;
      ST_ACS:    if (cor_done) state_nxt = pass_r ? ST_FIN : ST_DIV_GO;
      ST_FIN:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // unit controls and multiplier operands
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    cor_start = 1'b0;
    cor_yy    = 16'(z_r);
    cor_xx    = 16'(y_r);
    sq_start  = 1'b0;
    sq_val    = {2'b0, c2_r, 16'b0};
    dv_start  = 1'b0;
    dv_num    = pass_r ? num2 : num1;
    // first pass: the 2b*c product from ST_DEN sits in prod_r during ST_DIV_GO
    dv_den    = pass_r ? {11'b0, ab_r, 1'b0} : prod_r[37:0];
    dv_hi     = !pass_r;
    case (state_r)
      ST_YY: begin
        mul_a = 25'(y_r);
        mul_b = 25'(y_r);
      end
      ST_ZZ: begin
        mul_a = 25'(z_r);
        mul_b = 25'(z_r);
      end
      ST_MX: begin
        mul_a = $signed({11'b0, max_r});
        mul_b = $signed({11'b0, max_r});
      end
      ST_MN: begin
        mul_a = $signed({11'b0, min_r});
        mul_b = $signed({11'b0, min_r});
      end
      ST_AA: begin
        mul_a = $signed({12'b0, upper_r});
        mul_b = $signed({12'b0, upper_r});
      end
      ST_BB: begin
        mul_a = $signed({12'b0, lower_r});
        mul_b = $signed({12'b0, lower_r});
      end
      ST_AB: begin
        mul_a = $signed({12'b0, upper_r});
        mul_b = $signed({12'b0, lower_r});
      end
      ST_CHK:    cor_start = in_reach;
      ST_SQC_GO: sq_start = 1'b1;
      ST_DEN: begin
        mul_a = $signed({11'b0, lower_r, 1'b0});
        mul_b = $signed({2'b0, cq_r});
      end
      ST_DIV_GO: dv_start = 1'b1;
      ST_RSQ: begin
        mul_a = 25'(r_r);
        mul_b = 25'(r_r);
      end
      ST_SQR_GO: begin
        sq_start = 1'b1;
        sq_val   = 48'(ONE_Q14 * ONE_Q14) - {19'b0, prod_r[28:0]};
      end
      ST_SQR: begin
        cor_start = sq_done;
        cor_yy    = $signed(sq_root[15:0]);
        cor_xx    = r_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sh_r        <= '0;
      el_r        <= '0;
      wr_r        <= '0;
      reach_out_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
        reach_out_r <= reach_r;
        if (reach_r) begin
          sh_r <= sh16;
          el_r <= el16;
          wr_r <= wr16;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          y_r    <= in_ch.pos_y;
          z_r    <= in_ch.pos_z[14] ? 15'sd0 : in_ch.pos_z;
          pass_r <= 1'b0;
        end
      end
      ST_ZZ:  c2_r  <= prod_r[29:0];
      ST_MX:  c2_r  <= c2_r + prod_r[29:0];
      ST_MN:  mx2_r <= prod_r[27:0];
      ST_AA:  mn2_r <= prod_r[27:0];
      ST_BB:  aa_r  <= prod_r[25:0];
      ST_AB:  bb_r  <= prod_r[25:0];
      ST_CHK: begin
        ab_r    <= prod_r[25:0];
        reach_r <= in_reach;
      end
      ST_BRG:    if (cor_done) bearing_r <= cor_ang;
      ST_SQC:    if (sq_done) cq_r <= sq_root[22:0];
      ST_DIV:    if (dv_done) r_r <= dv_quot;
      ST_ACS: begin
        if (cor_done) begin
          if (pass_r) ac2_r <= cor_ang;
          else ac1_r <= cor_ang;
          pass_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  tlik_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .yy    (cor_yy),
    .xx    (cor_xx),
    .done  (cor_done),
    .ang   (cor_ang)
  );

  tlik_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .val   (sq_val),
    .done  (sq_done),
    .root  (sq_root)
  );

  tlik_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .num      (dv_num),
    .den      (dv_den),
    .shift_hi (dv_hi),
    .done     (dv_done),
    .quot     (dv_quot)
  );

  assign out_ch.valid          = out_valid_r;
  assign out_ch.shoulder_angle = sh_r;
  assign out_ch.elbow_angle    = el_r;
  assign out_ch.wrist_angle    = wr_r;
  assign out_ch.reachable      = reach_out_r;

endmodule

>>> src/tlik_checker.sv
// ----------------------------------------------------------------------------
// tlik_checker
// Port-level checks of the arm kinematics block, bound to the top level.
// ----------------------------------------------------------------------------
`include "two_link_arm_inverse_kinematics_assert.svh"

module tlik_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] shoulder_angle,
  input logic [15:0] elbow_angle,
  input logic [15:0] wrist_angle,
  input logic        reachable
);

  `TLIK_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result word dropped while stalled")

  `TLIK_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(shoulder_angle) && $stable(elbow_angle) && $stable(wrist_angle) && $stable(reachable), "result word changed while stalled")

  `TLIK_ASSERT_NXT(a_in_busy, clk, rst_n, in_valid && in_ready, !in_ready, "input taken while computing")

  `TLIK_ASSERT_NXT(a_no_early, clk, rst_n, in_valid && in_ready, !$rose(out_valid), "result too early after input word")

endmodule

bind two_link_arm_inverse_kinematics tlik_checker u_tlik_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .shoulder_angle (out_ch.shoulder_angle),
  .elbow_angle    (out_ch.elbow_angle),
  .wrist_angle    (out_ch.wrist_angle),
  .reachable      (out_ch.reachable)
);

>>> sim/tb_ik_checker.sv
// ----------------------------------------------------------------------------
// tb_ik_checker
// Watches the target, angle and register channels, predicts the joint angles
// of every accepted target and compares them with the block's results.
// ----------------------------------------------------------------------------
module tb_ik_checker import tlik_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  tlik_in_if         in_ch,
  tlik_out_if        out_ch,
  tlik_cfg_if        cfg_ch,
  output int         fail_count,
  output int         pending,
  output int         result_count,
  output int         held_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] shoulder;
    logic signed [15:0] elbow;
    logic signed [15:0] wrist;
    logic               reachable;
  } angles_t;

  angles_t expected_angles[$];

  logic [12:0]        upper_len, lower_len;
  logic signed [15:0] elbow_off;
  logic [13:0]        reach_hi, reach_lo;
  logic               claw_down;
  logic signed [15:0] held_sh, held_el, held_wr;

  function automatic longint shr_floor(input longint v, input int n);
    return v >>> n;
  endfunction

  function automatic longint int_sqrt(input longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint atan_table(input int i);
    longint t[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                      131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                      256, 128, 64, 32, 16, 8, 4, 2};
    return t[i];
  endfunction

  // bearing in [0, pi] at 2^-24 rad, yy >= 0
  function automatic longint vector_angle(input longint yy, input longint xx);
    longint x, y, ang, nx;
    if (xx == 0 && yy == 0) return 0;
    if (xx < 0) begin
      x = yy; y = -xx; ang = HALF_PI_Q24;
    end else begin
      x = xx; y = yy; ang = 0;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
      if (y >= 0) begin
        nx = x + shr_floor(y, i); y = y - shr_floor(x, i); ang += atan_table(i);
      end else begin
        nx = x - shr_floor(y, i); y = y + shr_floor(x, i); ang -= atan_table(i);
      end
      x = nx;
    end
    return ang;
  endfunction

  function automatic longint cos_ratio(input longint num, input longint unsigned den,
                                       input int sh);
    longint unsigned mag, q;
    if (den == 0) return num > 0 ? ONE_Q14 : (num < 0 ? -ONE_Q14 : 0);
    mag = longint'(num < 0 ? -num : num) << sh;
    q = (mag + den / 2) / den;
    if (q > ONE_Q14) q = ONE_Q14;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint arc_cos(input longint r);
    return vector_angle(int_sqrt(longint'(ONE_Q14) * ONE_Q14 - r * r), r);
  endfunction

  function automatic longint clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic angles_t solve_joints(input logic signed [14:0] ty,
                                           input logic signed [14:0] tz);
    longint y, z, a, b, c2, cq, r1, r2, sh, el, wr;
    longint unsigned hi2, lo2;
    angles_t res;
    y = ty;
    z = (tz < 0) ? 0 : tz;
    a = upper_len;
    b = lower_len;
    c2 = y * y + z * z;
    hi2 = longint'(reach_hi) * reach_hi;
    lo2 = longint'(reach_lo) * reach_lo;
    res.reachable = !(c2 > hi2 || c2 < lo2);
    if (res.reachable) begin
      cq = int_sqrt(c2 << 16);
      r1 = cos_ratio(c2 + b * b - a * a, (2 * b) * cq, 22);
      r2 = cos_ratio(a * a + b * b - c2, 2 * a * b, 14);
      sh = clip16((longint'(PI_Q24) - (arc_cos(r1) + vector_angle(z, y)) + 2048) >>> 12);
      el = clip16((arc_cos(r2) - longint'(elbow_off) * 4096 + 2048) >>> 12);
      wr = clip16(el - sh + (claw_down ? longint'(DOWN_TRIM_Q12) : longint'(LEVEL_TRIM_Q12)));
      held_sh = 16'(sh);
      held_el = 16'(el);
      held_wr = 16'(wr);
    end
    res.shoulder = held_sh;
    res.elbow = held_el;
    res.wrist = held_wr;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    angles_t e;
    if (!rst_n) begin
      upper_len <= 13'd3021;
      lower_len <= 13'd2880;
      elbow_off <= 16'sd1256;
      reach_hi  <= 14'd5760;
      reach_lo  <= 14'd141;
      claw_down <= 1'b0;
      held_sh = '0;
      held_el = '0;
      held_wr = '0;
      expected_angles.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        result_count++;
        if (expected_angles.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          e = expected_angles.pop_front();
          if (out_ch.shoulder_angle !== e.shoulder)
            report_mismatch("shoulder", out_ch.shoulder_angle, e.shoulder);
          if (out_ch.elbow_angle !== e.elbow)
            report_mismatch("elbow", out_ch.elbow_angle, e.elbow);
          if (out_ch.wrist_angle !== e.wrist)
            report_mismatch("wrist", out_ch.wrist_angle, e.wrist);
          if (out_ch.reachable !== e.reachable)
            report_mismatch("reachable", out_ch.reachable, e.reachable);
          if (!e.reachable) held_count++;
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_angles.push_back(solve_joints(in_ch.pos_y, in_ch.pos_z));
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_idx_t'(cfg_ch.index))
          CFG_UPPER: upper_len <= cfg_ch.data[12:0];
          CFG_LOWER: lower_len <= cfg_ch.data[12:0];
          CFG_ELBOW: elbow_off <= cfg_ch.data;
          CFG_MAX:   reach_hi  <= cfg_ch.data[13:0];
          CFG_MIN:   reach_lo  <= cfg_ch.data[13:0];
          CFG_CLAW:  claw_down <= cfg_ch.data[0];
          default: ;
        endcase
      end
    end
    pending = expected_angles.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    result_count = 0;
    held_count = 0;
  end
endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives targets and register writes into the arm kinematics block under
// random idling and stalls; the checker predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_top import tlik_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending, result_count, held_count;
  int   idle_cycles;
  int   targets_sent;
  bit   no_idling;
  bit   hold_off;

  tlik_in_if  in_ch();
  tlik_out_if out_ch();
  tlik_cfg_if cfg_ch();

  always #5 clk = ~clk;

  two_link_arm_inverse_kinematics dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  tb_ik_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending(pending), .result_count(result_count),
    .held_count(held_count)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    no_idling = 1'b0;
    hold_off = 1'b0;
    targets_sent = 0;
  end

  // receiver: random stall bursts, or a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else if (!no_idling && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      repeat ($urandom_range(0, 2)) @(posedge clk);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_target(input logic signed [14:0] ty, input logic signed [14:0] tz);
    if (!no_idling && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pos_y <= ty;
    in_ch.pos_z <= tz;
    do @(posedge clk); while (!in_ch.ready);
    targets_sent++;
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
  endtask

  // leaves valid high; the caller drops it after the last write
  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic drain_results();
    end_burst();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_arm(input int a, input int b, input int off, input int hi,
                         input int lo, input int claw);
    drain_results();
    write_reg(CFG_UPPER, 16'(a));
    write_reg(CFG_LOWER, 16'(b));
    write_reg(CFG_ELBOW, 16'(off));
    write_reg(CFG_MAX, 16'(hi));
    write_reg(CFG_MIN, 16'(lo));
    write_reg(CFG_CLAW, 16'(claw));
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly targets with coordinates up to hi (at most 11000), some anywhere
  task automatic random_targets(input int count, input int hi);
    int r, ang_y, ang_z;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_target(15'($urandom), 15'($urandom));
      end else begin
        r = $urandom_range(0, hi > 11000 ? 11000 : hi);
        ang_y = $urandom_range(0, 2 * r) - r;
        ang_z = $urandom_range(0, r);
        if ($urandom_range(0, 7) == 0) ang_z = -ang_z;
        send_target(15'(ang_y), 15'(ang_z));
      end
    end
  endtask

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("watchdog expired with %0d words outstanding", pending);
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset arm, field extremes and the special cases
    send_target(15'sd0, 15'sd0);            // origin, below min reach
    send_target(15'sd3000, 15'sd0);
    send_target(15'sd0, 15'sd3000);
    send_target(-15'sd3000, 15'sd1000);
    send_target(15'sd2000, -15'sd2000);     // negative z clamped
    send_target(15'sd16383, 15'sd16383);    // beyond max reach
    send_target(15'sh4000, 15'sh4000);      // most negative on both
    send_target(15'sd5760, 15'sd0);        // exactly on max reach
    send_target(15'sd141, 15'sd0);         // exactly on min reach
    send_target(15'sd140, 15'sd0);
    send_target(15'sd5761, 15'sd0);
    send_target(-15'sd1, 15'sd1);
    send_target(15'sd10, 15'sd5000);
    set_arm(0, 0, 0, 16383, 0, 1);          // zero divisors, origin bearing
    send_target(15'sd0, 15'sd0);
    send_target(15'sd1000, 15'sd1000);
    send_target(15'sh4000, 15'sd0);
    set_arm(8191, 8191, 32767, 16383, 0, 0);
    send_target(15'sd16383, 15'sd16383);
    send_target(15'sd0, 15'sd50);
    set_arm(4000, 0, -32768, 16383, 16383, 1);
    send_target(-15'sd10000, 15'sd8000);
    set_arm(3000, 3000, 0, 100, 200, 0);    // empty window
    send_target(15'sd150, 15'sd0);

    // sender pauses until every result is in
    set_arm(3021, 2880, 1256, 5760, 141, 0);
    random_targets(40, 6000);
    drain_results();

    // long receiver hold-off while targets keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      random_targets(10, 6000);
    join

    set_arm($urandom_range(500, 8191), $urandom_range(500, 8191), $urandom, 16383,
            $urandom_range(0, 200), 1);
    random_targets(250, 16383);
    set_arm($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 300), 0);
    random_targets(250, 12000);
    set_arm(3021, 2880, 1256, 5760, 141, 1);
    no_idling = 1'b1;
    random_targets(300, 6000);
    drain_results();
    repeat (300) @(posedge clk);

    $display("sent %0d targets, checked %0d words, %0d of them held",
             targets_sent, result_count, held_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule

>>> two_link_arm_inverse_kinematics.f
+incdir+src
src/tlik_pkg.sv
src/tlik_in_if.sv
src/tlik_out_if.sv
src/tlik_cfg_if.sv
src/tlik_isqrt.sv
src/tlik_div.sv
src/tlik_cordic.sv
src/two_link_arm_inverse_kinematics.sv
src/tlik_checker.sv
sim/tb_ik_checker.sv
sim/tb_top.sv
